>>> hw/rtl/multi_button_lockout_debouncer_core_macros.svh
// assertion macros shared by the debouncer rtl
`ifndef MULTI_BUTTON_LOCKOUT_DEBOUNCER_CORE_MACROS_SVH
`define MULTI_BUTTON_LOCKOUT_DEBOUNCER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBLD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mbld_pkg.sv
// shared types and constants of the lockout debouncer
`default_nettype none

package mbld_pkg;

    localparam int unsigned NUM_BTN_MAX   = 16;
    localparam int unsigned BTN_IDX_W     = 4;
    localparam int unsigned PORT_W        = 8;
    localparam int unsigned LOCKOUT_W     = 16;
    localparam int unsigned NOW_W         = 32;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd20;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_HAND
    } t_eng_state;

    // finished scan handed from the engine to the result stage
    typedef struct packed {
        logic                   valid;
        logic [NUM_BTN_MAX-1:0] mask;
        logic [NUM_BTN_MAX-1:0] states;
    } t_hand;

endpackage

`default_nettype wire

>>> hw/rtl/mbld_queue.sv
// two-entry flop queue between the front and the engine
`default_nettype none

module mbld_queue #(
    parameter int unsigned WIDTH = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mbld_front.sv
// front end: takes scans, packs button levels, holds the lockout register
`default_nettype none

module mbld_front #(
    parameter int unsigned NUM_BUTTONS = 16,
    parameter int unsigned TIME_W      = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic [mbld_pkg::PORT_W-1:0]        i_port_a_bits,
    input  wire logic [mbld_pkg::PORT_W-1:0]        i_port_b_bits,
    input  wire logic [mbld_pkg::NOW_W-1:0]         i_now_ms,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mbld_pkg::LOCKOUT_W-1:0]     i_cfg_lockout_ms,
    output logic [mbld_pkg::LOCKOUT_W-1:0]          o_lockout,
    input  wire logic                               i_q_full,
    output logic                                    o_q_push,
    output logic [mbld_pkg::NUM_BTN_MAX+TIME_W-1:0] o_q_data
);

    import mbld_pkg::*;

    localparam logic [NUM_BTN_MAX-1:0] BTN_MASK =
        NUM_BTN_MAX'((33'd1 << NUM_BUTTONS) - 33'd1);

    logic [LOCKOUT_W-1:0]   r_lockout;
    logic [NUM_BTN_MAX-1:0] levels;

    assign o_cfg_ready = 1'b1;
    assign o_lockout   = r_lockout;

    // buttons past the configured count never see a level
    assign levels   = {i_port_b_bits, i_port_a_bits} & BTN_MASK;
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;
    assign o_q_data = {levels, i_now_ms[TIME_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lockout <= i_cfg_lockout_ms;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mbld_engine.sv
// scan engine: walks the buttons one a cycle against the lockout timers
`default_nettype none

`include "multi_button_lockout_debouncer_core_macros.svh"

module mbld_engine #(
    parameter int unsigned NUM_BUTTONS = 16,
    parameter int unsigned TIME_W      = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [mbld_pkg::LOCKOUT_W-1:0]     i_lockout,
    input  wire logic                               i_q_empty,
    input  wire logic [mbld_pkg::NUM_BTN_MAX+TIME_W-1:0] i_q_data,
    output logic                                    o_q_pop,
    output mbld_pkg::t_hand                         o_hand,
    input  wire logic                               i_hand_ready
);

    import mbld_pkg::*;

    localparam logic [BTN_IDX_W-1:0] LAST_IDX = BTN_IDX_W'(NUM_BUTTONS - 1);
    localparam logic [NUM_BTN_MAX-1:0] BTN_MASK =
        NUM_BTN_MAX'((33'd1 << NUM_BUTTONS) - 33'd1);

    t_eng_state             r_state;
    t_eng_state             n_state;
    logic [BTN_IDX_W-1:0]   r_idx;
    logic [BTN_IDX_W-1:0]   n_idx;
    logic [NUM_BTN_MAX-1:0] r_levels;
    logic [NUM_BTN_MAX-1:0] n_levels;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      n_now;
    logic [NUM_BTN_MAX-1:0] r_mask;
    logic [NUM_BTN_MAX-1:0] n_mask;
    logic [NUM_BTN_MAX-1:0] r_btn;
    logic [NUM_BTN_MAX-1:0] n_btn;
    logic [TIME_W-1:0]      r_time [NUM_BTN_MAX];

    logic                   load;
    logic                   scanning;
    logic [TIME_W-1:0]      prev;
    logic [TIME_W-1:0]      diff;
    logic                   chg;
    logic [TIME_W-1:0]      time_wr;
    logic [NUM_BTN_MAX-1:0] absent;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ENG_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ENG_SCAN;
                end
            end
            ENG_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ENG_HAND;
                end
            end
            ENG_HAND: begin
                if (i_hand_ready) begin
                    n_state = i_q_empty ? ENG_IDLE : ENG_SCAN;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        load     = 1'b0;
        scanning = 1'b0;
        o_hand   = '0;
        case (r_state)
            ENG_IDLE: begin
                load = !i_q_empty;
            end
            ENG_SCAN: begin
                scanning = 1'b1;
            end
            ENG_HAND: begin
                o_hand.valid  = 1'b1;
                o_hand.mask   = r_mask;
                o_hand.states = r_btn;
                load          = i_hand_ready && !i_q_empty;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_q_pop = load;

    // one button per cycle: lockout window and level compare
    assign prev = r_time[r_idx];
    assign diff = r_now - prev;
    assign chg  = (diff > TIME_W'(i_lockout)) && (r_levels[r_idx] != r_btn[r_idx]);
    // a stamp later than now is dropped to zero unless a change is accepted
    assign time_wr = chg ? r_now : ((prev > r_now) ? '0 : prev);

    always_comb begin
        n_idx    = r_idx;
        n_levels = r_levels;
        n_now    = r_now;
        n_mask   = r_mask;
        n_btn    = r_btn;
        if (load) begin
            n_idx    = '0;
            n_levels = i_q_data[NUM_BTN_MAX+TIME_W-1:TIME_W];
            n_now    = i_q_data[TIME_W-1:0];
            n_mask   = '0;
        end else if (scanning) begin
            n_idx = r_idx + BTN_IDX_W'(1);
            if (chg) begin
                n_mask[r_idx] = 1'b1;
                n_btn[r_idx]  = r_levels[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
            r_idx   <= '0;
            r_mask  <= '0;
            r_btn   <= '0;
            for (int i = 0; i < NUM_BTN_MAX; i++) begin
                r_time[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_mask  <= n_mask;
            r_btn   <= n_btn;
            if (scanning) begin
                r_time[r_idx] <= time_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_levels <= n_levels;
        r_now    <= n_now;
    end

    // bits of buttons past the configured count in the handed scan
    assign absent = (o_hand.mask | o_hand.states) & ~BTN_MASK;

    `MBLD_ASSERT(a_idx_range, r_state == ENG_SCAN, r_idx <= LAST_IDX, "scan index too high")
    `MBLD_ASSERT(a_hand_absent, o_hand.valid, absent == '0, "absent button changed")
    `MBLD_ASSERT(a_hand_evt, o_hand.valid, o_hand.states == r_btn, "handoff states stale")

endmodule

`default_nettype wire

>>> hw/rtl/mbld_emit.sv
// result stage: serialises the events of one finished scan
`default_nettype none

`include "multi_button_lockout_debouncer_core_macros.svh"

module mbld_emit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mbld_pkg::t_hand                    i_hand,
    output logic                                    o_hand_ready,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    o_event_valid,
    output logic [mbld_pkg::BTN_IDX_W-1:0]          o_button_index,
    output logic                                    o_now_pressed,
    output logic [mbld_pkg::NUM_BTN_MAX-1:0]        o_all_states,
    output logic                                    o_last_of_scan
);

    import mbld_pkg::*;

    logic                   r_busy;
    logic                   r_quiet;
    logic [NUM_BTN_MAX-1:0] r_mask;
    logic [NUM_BTN_MAX-1:0] r_states;
    logic [NUM_BTN_MAX-1:0] rest;
    logic [BTN_IDX_W-1:0]   enc;
    logic                   last;
    logic                   take;

    // lowest pending event first
    always_comb begin
        enc = '0;
        for (int i = NUM_BTN_MAX - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                enc = BTN_IDX_W'(i);
            end
        end
    end

    assign rest         = r_mask & (r_mask - NUM_BTN_MAX'(1));
    assign last         = r_quiet || (rest == '0);
    assign take         = pop && r_busy;
    assign o_hand_ready = !r_busy || (take && last);

    assign empty          = !r_busy;
    assign o_event_valid  = !r_quiet;
    assign o_button_index = r_quiet ? '0 : enc;
    assign o_now_pressed  = r_quiet ? 1'b0 : r_states[enc];
    assign o_all_states   = r_states;
    assign o_last_of_scan = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_hand.valid && o_hand_ready) begin
            r_busy <= 1'b1;
        end else if (take && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hand.valid && o_hand_ready) begin
            r_mask   <= i_hand.mask;
            r_states <= i_hand.states;
            r_quiet  <= (i_hand.mask == '0);
        end else if (take) begin
            r_mask <= rest;
        end
    end

    `MBLD_ASSERT(a_busy_mask, r_busy && !r_quiet, r_mask != '0, "event result with no change")
    `MBLD_ASSERT_NEXT(a_load_busy, i_hand.valid && o_hand_ready, r_busy, "handed scan not held")
    `MBLD_ASSERT(a_ready_free, !r_busy, o_hand_ready, "idle result stage refuses a scan")

endmodule

`default_nettype wire

>>> hw/rtl/multi_button_lockout_debouncer_core.sv
// Lockout debouncer for up to sixteen buttons sampled from two 8-bit ports.
// Input channel: push/full carries one scan (port_a_bits, port_b_bits, now_ms);
// a scan is taken when push is high and full is low. A two-entry queue holds
// scans until the engine is free.
// Result channel: empty/pop; each scan gives one result per accepted button
// change in ascending button order, or a single quiet result, and the last
// one carries last_of_scan. all_states is the state after the whole scan.
// Configuration: cfg valid/ready (ready always high) writes lockout_ms.
// Flow: the engine tests one button a cycle against its timestamp, then
// hands the finished scan to the result stage. Results leave one a cycle
// while pop is high. The result stage drains one scan while the engine
// works on the next, so a new scan can be started before all results of
// the last one have left.
// Reset: all buttons released, timestamps zero, lockout 20, queues empty.
// Stalls: while pop is held low the result stays put, the engine waits at
// handoff, the queue fills and full rises.
`default_nettype none

module multi_button_lockout_debouncer_core #(
    parameter int unsigned NUM_BUTTONS = 16,
    parameter int unsigned TIME_BITS   = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [mbld_pkg::PORT_W-1:0]        i_port_a_bits,
    input  wire logic [mbld_pkg::PORT_W-1:0]        i_port_b_bits,
    input  wire logic [mbld_pkg::NOW_W-1:0]         i_now_ms,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    o_event_valid,
    output logic [mbld_pkg::BTN_IDX_W-1:0]          o_button_index,
    output logic                                    o_now_pressed,
    output logic [mbld_pkg::NUM_BTN_MAX-1:0]        o_all_states,
    output logic                                    o_last_of_scan,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mbld_pkg::LOCKOUT_W-1:0]     i_cfg_lockout_ms
);

    import mbld_pkg::*;

    // times never run wider than the input field
    localparam int unsigned TIME_W = (TIME_BITS >= NOW_W) ? NOW_W : TIME_BITS;
    localparam int unsigned Q_W    = NUM_BTN_MAX + TIME_W;

    logic [LOCKOUT_W-1:0] lockout;
    logic                 q_push;
    logic [Q_W-1:0]       q_wdata;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    logic [Q_W-1:0]       q_rdata;
    t_hand                hand;
    logic                 hand_ready;

    mbld_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_W      (TIME_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_port_a_bits    (i_port_a_bits),
        .i_port_b_bits    (i_port_b_bits),
        .i_now_ms         (i_now_ms),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_lockout_ms (i_cfg_lockout_ms),
        .o_lockout        (lockout),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_data         (q_wdata)
    );

    mbld_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    mbld_engine #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_W      (TIME_W)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lockout    (lockout),
        .i_q_empty    (q_empty),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_hand       (hand),
        .i_hand_ready (hand_ready)
    );

    mbld_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hand         (hand),
        .o_hand_ready   (hand_ready),
        .empty          (empty),
        .pop            (pop),
        .o_event_valid  (o_event_valid),
        .o_button_index (o_button_index),
        .o_now_pressed  (o_now_pressed),
        .o_all_states   (o_all_states),
        .o_last_of_scan (o_last_of_scan)
    );

endmodule

`default_nettype wire
